// ===== design/nl_lex_pkg.sv =====
package nl_lex_pkg;

   parameter int MAX_TOKEN_LEN_DEFAULT = 65535;

   parameter logic [4:0] K_WORD   = 5'd0;
   parameter logic [4:0] K_NUMBER = 5'd1;
   parameter logic [4:0] K_MODULE = 5'd2;
   parameter logic [4:0] K_LPAREN = 5'd8;
   parameter logic [4:0] K_RPAREN = 5'd9;
   parameter logic [4:0] K_LBRACK = 5'd10;
   parameter logic [4:0] K_RBRACK = 5'd11;
   parameter logic [4:0] K_COMMA  = 5'd12;
   parameter logic [4:0] K_DOT    = 5'd13;
   parameter logic [4:0] K_SEMI   = 5'd14;
   parameter logic [4:0] K_COLON  = 5'd15;
   parameter logic [4:0] K_EQUAL  = 5'd16;
   parameter logic [4:0] K_QUOTE  = 5'd17;
   parameter logic [4:0] K_EOF    = 5'd18;
   parameter logic [4:0] K_ERROR  = 5'd19;

   parameter logic [7:0] CH_TAB    = 8'h09;
   parameter logic [7:0] CH_LF     = 8'h0A;
   parameter logic [7:0] CH_CR     = 8'h0D;
   parameter logic [7:0] CH_SPACE  = 8'h20;
   parameter logic [7:0] CH_DOLLAR = 8'h24;
   parameter logic [7:0] CH_TICK   = 8'h27;
   parameter logic [7:0] CH_LPAREN = 8'h28;
   parameter logic [7:0] CH_RPAREN = 8'h29;
   parameter logic [7:0] CH_STAR   = 8'h2A;
   parameter logic [7:0] CH_COMMA  = 8'h2C;
   parameter logic [7:0] CH_DOT    = 8'h2E;
   parameter logic [7:0] CH_SLASH  = 8'h2F;
   parameter logic [7:0] CH_COLON  = 8'h3A;
   parameter logic [7:0] CH_SEMI   = 8'h3B;
   parameter logic [7:0] CH_EQUAL  = 8'h3D;
   parameter logic [7:0] CH_LBRACK = 8'h5B;
   parameter logic [7:0] CH_BSLASH = 8'h5C;
   parameter logic [7:0] CH_RBRACK = 8'h5D;
   parameter logic [7:0] CH_UNDER  = 8'h5F;

   parameter int KW_COUNT = 6;
   parameter int KW_CHARS = 9;

   parameter logic [0:KW_COUNT-1][0:KW_CHARS-1][7:0] KW_TEXT = '{
      '{"m", "o", "d", "u", "l", "e", 8'h00, 8'h00, 8'h00},
      '{"e", "n", "d", "m", "o", "d", "u", "l", "e"},
      '{"w", "i", "r", "e", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
      '{"i", "n", "p", "u", "t", 8'h00, 8'h00, 8'h00, 8'h00},
      '{"o", "u", "t", "p", "u", "t", 8'h00, 8'h00, 8'h00},
      '{"a", "s", "s", "i", "g", "n", 8'h00, 8'h00, 8'h00}
   };
   parameter logic [0:KW_COUNT-1][15:0] KW_LEN = '{16'd6, 16'd9, 16'd4, 16'd5, 16'd6, 16'd6};

   parameter logic [62:0] VAL_MAX = {63{1'b1}};

   typedef struct packed {
      logic [4:0]  kind;
      logic [62:0] value;
      logic [31:0] line;
      logic [15:0] column;
      logic [15:0] length;
      logic        last;
   } result_type;

   function automatic result_type make_result(input logic [4:0] kind, input logic [62:0] value,
                                              input logic [31:0] line,
                                              input logic [15:0] column,
                                              input logic [15:0] length);
      result_type r;
      r.kind   = kind;
      r.value  = value;
      r.line   = line;
      r.column = column;
      r.length = length;
      r.last   = 1'b0;
      return r;
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_UNDER;
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || c == CH_DOLLAR;
   endfunction

   function automatic logic is_punct(input logic [7:0] c);
      logic p;
      unique case (c)
         CH_RPAREN, CH_LBRACK, CH_RBRACK, CH_COMMA, CH_DOT,
         CH_SEMI, CH_COLON, CH_EQUAL, CH_TICK: p = 1'b1;
         default: p = 1'b0;
      endcase
      return p;
   endfunction

   function automatic logic [4:0] punct_kind(input logic [7:0] c);
      logic [4:0] k;
      unique case (c)
         CH_RPAREN: k = K_RPAREN;
         CH_LBRACK: k = K_LBRACK;
         CH_RBRACK: k = K_RBRACK;
         CH_COMMA:  k = K_COMMA;
         CH_DOT:    k = K_DOT;
         CH_SEMI:   k = K_SEMI;
         CH_COLON:  k = K_COLON;
         CH_EQUAL:  k = K_EQUAL;
         CH_TICK:   k = K_QUOTE;
         default:   k = K_ERROR;
      endcase
      return k;
   endfunction

endpackage

// ===== design/netlist_lexer.sv =====
// Channel   Direction  Handshake               Payload
// req_      in         req_valid / req_stall   char_byte, end_of_input
// rsp_      out        rsp_valid / rsp_stall   token kind, value, line, column, length, last
//
// One request is taken per cycle while req_stall is low. Its zero, one or two tokens
// are computed in the same cycle and written into a four-entry result queue, so they
// appear on rsp_ from the next cycle on, one per cycle while rsp_stall is low.
// req_stall rises while the queue holds three or more tokens.
// Synchronous reset empties the queue and returns the lexer to idle at line 1, column 0.
module netlist_lexer #(
   parameter int MAX_TOKEN_LEN = nl_lex_pkg::MAX_TOKEN_LEN_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_char_byte,
   input  logic        req_end_of_input,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_token_kind,
   output logic [62:0] rsp_number_value,
   output logic [31:0] rsp_token_line,
   output logic [15:0] rsp_token_column,
   output logic [15:0] rsp_token_length,
   output logic        rsp_last_of_run
);

   typedef enum logic [3:0] {
      M_IDLE, M_WORD, M_NUMBER, M_ESCAPE, M_SLASH, M_PAREN, M_COMMENT, M_STAR, M_HALTED
   } mode_type;

   localparam logic [15:0] LEN_MAX = 16'(MAX_TOKEN_LEN);

   mode_type    mode_ff, mode_in;
   logic [63:0] acc_ff, acc_in;
   logic [15:0] wlen_ff, wlen_in;
   logic [31:0] line_ff, line_in;
   logic [15:0] col_ff, col_in;
   logic [31:0] sline_ff, sline_in;
   logic [15:0] scol_ff, scol_in;
   logic        closer_ff, closer_in;
   logic [7:0]  kbuf_ff [nl_lex_pkg::KW_CHARS];

   nl_lex_pkg::result_type queue_ff [4];
   logic [1:0] rd_ptr_ff, wr_ptr_ff;
   logic [2:0] count_ff;

   logic        take, pop;
   logic [7:0]  c;
   logic        buf_we;
   logic [3:0]  buf_idx;
   logic        fresh;
   logic        a_v, b_v;
   nl_lex_pkg::result_type a_res, b_res, slot0, slot1;
   logic [1:0]  push_n;
   logic [4:0]  word_kind;
   logic [66:0] prod;
   logic [15:0] wlen_inc;

   assign c        = req_char_byte;
   assign take     = req_valid && !req_stall;
   assign pop      = rsp_valid && !rsp_stall;
   assign req_stall = count_ff > 3'd2;
   assign wlen_inc = (wlen_ff < LEN_MAX) ? wlen_ff + 16'd1 : wlen_ff;
   assign prod     = ({4'b0, acc_ff[62:0]} << 3) + ({4'b0, acc_ff[62:0]} << 1)
                     + {63'b0, c[3:0]};

   always_comb begin
      logic match;
      word_kind = nl_lex_pkg::K_WORD;
      for (int i = 0; i < nl_lex_pkg::KW_COUNT; i++) begin
         match = (wlen_ff == nl_lex_pkg::KW_LEN[i]);
         for (int j = 0; j < nl_lex_pkg::KW_CHARS; j++) begin
            if (16'(j) < nl_lex_pkg::KW_LEN[i] && kbuf_ff[j] != nl_lex_pkg::KW_TEXT[i][j]) begin
               match = 1'b0;
            end
         end
         if (match) begin
            word_kind = nl_lex_pkg::K_MODULE + 5'(i);
         end
      end
   end

   always_comb begin
      mode_in   = mode_ff;
      acc_in    = acc_ff;
      wlen_in   = wlen_ff;
      line_in   = line_ff;
      col_in    = col_ff;
      sline_in  = sline_ff;
      scol_in   = scol_ff;
      closer_in = closer_ff;
      buf_we    = 1'b0;
      buf_idx   = wlen_ff[3:0];
      fresh     = 1'b0;
      a_v       = 1'b0;
      b_v       = 1'b0;
      a_res     = nl_lex_pkg::make_result(nl_lex_pkg::K_EOF, '0, line_ff, col_ff, '0);
      b_res     = a_res;
      if (take && mode_ff != M_HALTED) begin
         if (req_end_of_input) begin
            unique case (mode_ff)
               M_WORD: begin
                  a_v = 1'b1;
                  a_res = nl_lex_pkg::make_result(word_kind, '0, sline_ff, scol_ff, wlen_ff);
                  mode_in = M_IDLE;
               end
               M_NUMBER: begin
                  a_v = 1'b1;
                  if (acc_ff[63]) begin
                     a_res = nl_lex_pkg::make_result(nl_lex_pkg::K_ERROR, nl_lex_pkg::VAL_MAX,
                                                     sline_ff, scol_ff, wlen_ff);
                     mode_in = M_HALTED;
                  end else begin
                     a_res = nl_lex_pkg::make_result(nl_lex_pkg::K_NUMBER, acc_ff[62:0],
                                                     sline_ff, scol_ff, wlen_ff);
                     mode_in = M_IDLE;
                  end
               end
               M_ESCAPE: begin
                  a_v = 1'b1;
                  a_res = nl_lex_pkg::make_result(nl_lex_pkg::K_WORD, '0, sline_ff, scol_ff,
                                                  wlen_ff);
                  mode_in = M_IDLE;
               end
               M_PAREN: begin
                  a_v = 1'b1;
                  a_res = nl_lex_pkg::make_result(nl_lex_pkg::K_LPAREN, '0, sline_ff, scol_ff,
                                                  16'd1);
                  mode_in = M_IDLE;
               end
               M_SLASH, M_COMMENT, M_STAR: begin
                  a_v = 1'b1;
                  a_res = nl_lex_pkg::make_result(nl_lex_pkg::K_ERROR, '0, line_ff, col_ff, '0);
                  mode_in = M_HALTED;
               end
               default: ;
            endcase
            if (mode_in != M_HALTED) begin
               b_v = 1'b1;
               b_res = nl_lex_pkg::make_result(nl_lex_pkg::K_EOF, '0, line_ff, col_ff, '0);
               mode_in = M_IDLE;
            end
         end else begin
            unique case (mode_ff)
               M_WORD: begin
                  if (nl_lex_pkg::is_alnum(c)) begin
                     buf_we = wlen_ff < 16'(nl_lex_pkg::KW_CHARS);
                     wlen_in = wlen_inc;
                  end else begin
                     a_v = 1'b1;
                     a_res = nl_lex_pkg::make_result(word_kind, '0, sline_ff, scol_ff, wlen_ff);
                     mode_in = M_IDLE;
                     fresh = 1'b1;
                  end
               end
               M_NUMBER: begin
                  if (nl_lex_pkg::is_digit(c)) begin
                     if (!acc_ff[63]) begin
                        acc_in = (prod[66:63] != 4'd0) ? {1'b1, 63'b0} : {1'b0, prod[62:0]};
                     end
                     wlen_in = wlen_inc;
                  end else begin
                     a_v = 1'b1;
                     if (acc_ff[63]) begin
                        a_res = nl_lex_pkg::make_result(nl_lex_pkg::K_ERROR,
                                                        nl_lex_pkg::VAL_MAX, sline_ff, scol_ff,
                                                        wlen_ff);
                        mode_in = M_HALTED;
                     end else begin
                        a_res = nl_lex_pkg::make_result(nl_lex_pkg::K_NUMBER, acc_ff[62:0],
                                                        sline_ff, scol_ff, wlen_ff);
                        mode_in = M_IDLE;
                        fresh = 1'b1;
                     end
                  end
               end
               M_ESCAPE: begin
                  if (nl_lex_pkg::is_space(c)) begin
                     a_v = 1'b1;
                     a_res = nl_lex_pkg::make_result(nl_lex_pkg::K_WORD, '0, sline_ff, scol_ff,
                                                     wlen_ff);
                     mode_in = M_IDLE;
                  end else begin
                     wlen_in = wlen_inc;
                  end
               end
               M_SLASH: begin
                  if (c == nl_lex_pkg::CH_STAR) begin
                     mode_in = M_COMMENT;
                     closer_in = 1'b0;
                  end else begin
                     a_v = 1'b1;
                     a_res = nl_lex_pkg::make_result(nl_lex_pkg::K_ERROR, '0, line_ff, col_ff,
                                                     '0);
                     mode_in = M_HALTED;
                  end
               end
               M_PAREN: begin
                  if (c == nl_lex_pkg::CH_STAR) begin
                     mode_in = M_COMMENT;
                     closer_in = 1'b1;
                  end else begin
                     a_v = 1'b1;
                     a_res = nl_lex_pkg::make_result(nl_lex_pkg::K_LPAREN, '0, sline_ff,
                                                     scol_ff, 16'd1);
                     mode_in = M_IDLE;
                     fresh = 1'b1;
                  end
               end
               M_COMMENT: begin
                  if (c == nl_lex_pkg::CH_STAR) begin
                     mode_in = M_STAR;
                  end
               end
               M_STAR: begin
                  if (c == (closer_ff ? nl_lex_pkg::CH_RPAREN : nl_lex_pkg::CH_SLASH)) begin
                     mode_in = M_IDLE;
                  end else if (c != nl_lex_pkg::CH_STAR) begin
                     mode_in = M_COMMENT;
                  end
               end
               default: fresh = 1'b1;
            endcase

            if (fresh && !nl_lex_pkg::is_space(c)) begin
               if (c == nl_lex_pkg::CH_SLASH || c == nl_lex_pkg::CH_LPAREN ||
                   c == nl_lex_pkg::CH_BSLASH || nl_lex_pkg::is_alpha(c) ||
                   nl_lex_pkg::is_digit(c)) begin
                  sline_in = line_ff;
                  scol_in  = col_ff;
                  wlen_in  = 16'd1;
                  if (c == nl_lex_pkg::CH_SLASH) begin
                     mode_in = M_SLASH;
                  end else if (c == nl_lex_pkg::CH_LPAREN) begin
                     mode_in = M_PAREN;
                  end else if (c == nl_lex_pkg::CH_BSLASH) begin
                     mode_in = M_ESCAPE;
                  end else if (nl_lex_pkg::is_alpha(c)) begin
                     mode_in = M_WORD;
                     buf_we  = 1'b1;
                     buf_idx = 4'd0;
                  end else begin
                     mode_in = M_NUMBER;
                     acc_in  = {60'b0, c[3:0]};
                  end
               end else if (nl_lex_pkg::is_punct(c)) begin
                  b_v = 1'b1;
                  b_res = nl_lex_pkg::make_result(nl_lex_pkg::punct_kind(c), '0, line_ff,
                                                  col_ff, 16'd1);
               end else begin
                  b_v = 1'b1;
                  b_res = nl_lex_pkg::make_result(nl_lex_pkg::K_ERROR, '0, line_ff, col_ff,
                                                  '0);
                  mode_in = M_HALTED;
               end
            end

            if (c == nl_lex_pkg::CH_LF) begin
               if (line_ff != 32'hFFFF_FFFF) begin
                  line_in = line_ff + 32'd1;
               end
               col_in = 16'd0;
            end else if (col_ff != 16'hFFFF) begin
               col_in = col_ff + 16'd1;
            end
         end
      end
   end

   always_comb begin
      push_n = {1'b0, a_v} + {1'b0, b_v};
      slot0 = a_v ? a_res : b_res;
      slot1 = b_res;
      slot0.last = !(a_v && b_v);
      slot1.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= M_IDLE;
         acc_ff    <= '0;
         wlen_ff   <= '0;
         line_ff   <= 32'd1;
         col_ff    <= '0;
         sline_ff  <= 32'd1;
         scol_ff   <= '0;
         closer_ff <= 1'b0;
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         mode_ff   <= mode_in;
         acc_ff    <= acc_in;
         wlen_ff   <= wlen_in;
         line_ff   <= line_in;
         col_ff    <= col_in;
         sline_ff  <= sline_in;
         scol_ff   <= scol_in;
         closer_ff <= closer_in;
         rd_ptr_ff <= rd_ptr_ff + {1'b0, pop};
         wr_ptr_ff <= wr_ptr_ff + push_n;
         count_ff  <= count_ff + {1'b0, push_n} - {2'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (buf_we) begin
         kbuf_ff[buf_idx] <= c;
      end
      if (push_n != 2'd0) begin
         queue_ff[wr_ptr_ff] <= slot0;
      end
      if (push_n == 2'd2) begin
         queue_ff[wr_ptr_ff + 2'd1] <= slot1;
      end
   end

   assign rsp_valid        = count_ff != 3'd0;
   assign rsp_token_kind   = queue_ff[rd_ptr_ff].kind;
   assign rsp_number_value = queue_ff[rd_ptr_ff].value;
   assign rsp_token_line   = queue_ff[rd_ptr_ff].line;
   assign rsp_token_column = queue_ff[rd_ptr_ff].column;
   assign rsp_token_length = queue_ff[rd_ptr_ff].length;
   assign rsp_last_of_run  = queue_ff[rd_ptr_ff].last;

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd4)
      else $error("result queue overflow");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      mode_ff == M_HALTED |=> mode_ff == M_HALTED)
      else $error("lexer left the halted state without reset");

   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      take && mode_ff == M_HALTED |-> push_n == 2'd0)
      else $error("token produced while halted");

   a_end_answers: assert property (@(posedge clock) disable iff (reset)
      take && req_end_of_input && mode_ff != M_HALTED |-> push_n != 2'd0)
      else $error("end mark produced no token");

endmodule

// ===== tb/netlist_lexer_checker.sv =====
`timescale 1ns / 100ps
module netlist_lexer_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_char_byte,
   input  logic        req_end_of_input,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [4:0]  rsp_token_kind,
   input  logic [62:0] rsp_number_value,
   input  logic [31:0] rsp_token_line,
   input  logic [15:0] rsp_token_column,
   input  logic [15:0] rsp_token_length,
   input  logic        rsp_last_of_run,
   output int          fail_count,
   output int          pending
);

   localparam logic [15:0] LEN_CAP = 16'(nl_lex_pkg::MAX_TOKEN_LEN_DEFAULT);

   typedef enum logic [3:0] {
      LX_IDLE, LX_WORD, LX_NUMBER, LX_ESCAPE, LX_SLASH,
      LX_PAREN, LX_COMMENT, LX_STAR, LX_HALTED
   } lex_mode_type;

   lex_mode_type mode;
   logic [63:0]  acc;
   logic [7:0]   kw_buf [0:8];
   logic [15:0]  wlen;
   logic [31:0]  cur_line;
   logic [15:0]  cur_col;
   logic [31:0]  tok_line;
   logic [15:0]  tok_col;
   logic         closer_paren;
   int           errs;

   nl_lex_pkg::result_type want_ring [0:15];
   logic [3:0]             rd_idx;
   logic [3:0]             wr_idx;
   int                     fill;
   nl_lex_pkg::result_type run_tokens [0:1];
   int                     run_count;

   function automatic logic blank_char(input logic [7:0] c);
      return c == nl_lex_pkg::CH_SPACE || c == nl_lex_pkg::CH_TAB ||
             c == nl_lex_pkg::CH_CR || c == nl_lex_pkg::CH_LF;
   endfunction

   function automatic logic digit_char(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic logic letter_char(input logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == nl_lex_pkg::CH_UNDER;
   endfunction

   function automatic logic [4:0] punct_code(input logic [7:0] c);
      case (c)
         nl_lex_pkg::CH_RPAREN: return nl_lex_pkg::K_RPAREN;
         nl_lex_pkg::CH_LBRACK: return nl_lex_pkg::K_LBRACK;
         nl_lex_pkg::CH_RBRACK: return nl_lex_pkg::K_RBRACK;
         nl_lex_pkg::CH_COMMA:  return nl_lex_pkg::K_COMMA;
         nl_lex_pkg::CH_DOT:    return nl_lex_pkg::K_DOT;
         nl_lex_pkg::CH_SEMI:   return nl_lex_pkg::K_SEMI;
         nl_lex_pkg::CH_COLON:  return nl_lex_pkg::K_COLON;
         nl_lex_pkg::CH_EQUAL:  return nl_lex_pkg::K_EQUAL;
         nl_lex_pkg::CH_TICK:   return nl_lex_pkg::K_QUOTE;
         default:               return nl_lex_pkg::K_ERROR;
      endcase
   endfunction

   task automatic add_token(input logic [4:0] kind, input logic [62:0] value,
                            input logic [31:0] line, input logic [15:0] col,
                            input logic [15:0] len);
      nl_lex_pkg::result_type t;
      t.kind   = kind;
      t.value  = value;
      t.line   = line;
      t.column = col;
      t.length = len;
      t.last   = 1'b0;
      if (run_count < 2) run_tokens[1'(run_count)] = t;
      run_count++;
   endtask

   task automatic close_word_tok();
      logic [4:0] kind;
      logic       hit;
      kind = nl_lex_pkg::K_WORD;
      for (int i = 0; i < nl_lex_pkg::KW_COUNT; i++) begin
         if (wlen == nl_lex_pkg::KW_LEN[i]) begin
            hit = 1'b1;
            for (int j = 0; j < nl_lex_pkg::KW_LEN[i]; j++) begin
               if (kw_buf[j] != nl_lex_pkg::KW_TEXT[i][j]) hit = 1'b0;
            end
            if (hit) kind = nl_lex_pkg::K_MODULE + 5'(i);
         end
      end
      mode = LX_IDLE;
      add_token(kind, 63'd0, tok_line, tok_col, wlen);
   endtask

   task automatic close_number_tok();
      if (acc[63]) begin
         mode = LX_HALTED;
         add_token(nl_lex_pkg::K_ERROR, nl_lex_pkg::VAL_MAX, tok_line, tok_col, wlen);
      end else begin
         mode = LX_IDLE;
         add_token(nl_lex_pkg::K_NUMBER, acc[62:0], tok_line, tok_col, wlen);
      end
   endtask

   task automatic start_token(input lex_mode_type m, input logic [31:0] pl,
                              input logic [15:0] pc);
      mode = m;
      tok_line = pl;
      tok_col = pc;
      wlen = 16'd1;
   endtask

   task automatic predict_request(input logic [7:0] c, input logic eoi);
      logic [31:0]            pl;
      logic [15:0]            pc;
      logic                   fresh;
      logic [4:0]             pk;
      logic [63:0]            d;
      nl_lex_pkg::result_type tok;
      pl = cur_line;
      pc = cur_col;
      fresh = 1'b0;
      run_count = 0;
      if (mode == LX_HALTED) return;
      if (eoi) begin
         case (mode)
            LX_WORD:   close_word_tok();
            LX_NUMBER: close_number_tok();
            LX_ESCAPE: begin
               mode = LX_IDLE;
               add_token(nl_lex_pkg::K_WORD, 63'd0, tok_line, tok_col, wlen);
            end
            LX_PAREN: begin
               add_token(nl_lex_pkg::K_LPAREN, 63'd0, tok_line, tok_col, 16'd1);
               mode = LX_IDLE;
            end
            LX_SLASH, LX_COMMENT, LX_STAR: begin
               add_token(nl_lex_pkg::K_ERROR, 63'd0, pl, pc, 16'd0);
               mode = LX_HALTED;
            end
            default: ;
         endcase
         if (mode != LX_HALTED) begin
            add_token(nl_lex_pkg::K_EOF, 63'd0, pl, pc, 16'd0);
            mode = LX_IDLE;
         end
      end else begin
         case (mode)
            LX_WORD: begin
               if (letter_char(c) || digit_char(c) || c == nl_lex_pkg::CH_DOLLAR) begin
                  if (wlen < 16'd9) kw_buf[wlen[3:0]] = c;
                  if (wlen < LEN_CAP) wlen++;
               end else begin
                  close_word_tok();
                  fresh = 1'b1;
               end
            end
            LX_NUMBER: begin
               if (digit_char(c)) begin
                  d = 64'(c - 8'h30);
                  if (acc[63]) begin
                  end else if (acc > ({1'b0, nl_lex_pkg::VAL_MAX} - d) / 64'd10) begin
                     acc = 64'h8000_0000_0000_0000;
                  end else begin
                     acc = acc * 64'd10 + d;
                  end
                  if (wlen < LEN_CAP) wlen++;
               end else begin
                  close_number_tok();
                  fresh = (mode != LX_HALTED);
               end
            end
            LX_ESCAPE: begin
               if (blank_char(c)) begin
                  mode = LX_IDLE;
                  add_token(nl_lex_pkg::K_WORD, 63'd0, tok_line, tok_col, wlen);
               end else if (wlen < LEN_CAP) begin
                  wlen++;
               end
            end
            LX_SLASH: begin
               if (c == nl_lex_pkg::CH_STAR) begin
                  mode = LX_COMMENT;
                  closer_paren = 1'b0;
               end else begin
                  add_token(nl_lex_pkg::K_ERROR, 63'd0, pl, pc, 16'd0);
                  mode = LX_HALTED;
               end
            end
            LX_PAREN: begin
               if (c == nl_lex_pkg::CH_STAR) begin
                  mode = LX_COMMENT;
                  closer_paren = 1'b1;
               end else begin
                  add_token(nl_lex_pkg::K_LPAREN, 63'd0, tok_line, tok_col, 16'd1);
                  mode = LX_IDLE;
                  fresh = 1'b1;
               end
            end
            LX_COMMENT: begin
               if (c == nl_lex_pkg::CH_STAR) mode = LX_STAR;
            end
            LX_STAR: begin
               if (c == (closer_paren ? nl_lex_pkg::CH_RPAREN : nl_lex_pkg::CH_SLASH))
                  mode = LX_IDLE;
               else if (c != nl_lex_pkg::CH_STAR) mode = LX_COMMENT;
            end
            default: fresh = 1'b1;
         endcase

         if (fresh) begin
            pk = punct_code(c);
            if (blank_char(c)) begin
            end else if (c == nl_lex_pkg::CH_SLASH) begin
               start_token(LX_SLASH, pl, pc);
            end else if (c == nl_lex_pkg::CH_LPAREN) begin
               start_token(LX_PAREN, pl, pc);
            end else if (pk != nl_lex_pkg::K_ERROR) begin
               add_token(pk, 63'd0, pl, pc, 16'd1);
            end else if (c == nl_lex_pkg::CH_BSLASH) begin
               start_token(LX_ESCAPE, pl, pc);
            end else if (letter_char(c)) begin
               start_token(LX_WORD, pl, pc);
               kw_buf[0] = c;
            end else if (digit_char(c)) begin
               start_token(LX_NUMBER, pl, pc);
               acc = 64'(c - 8'h30);
            end else begin
               add_token(nl_lex_pkg::K_ERROR, 63'd0, pl, pc, 16'd0);
               mode = LX_HALTED;
            end
         end

         if (c == nl_lex_pkg::CH_LF) begin
            if (cur_line != 32'hFFFF_FFFF) cur_line++;
            cur_col = 16'd0;
         end else if (cur_col != 16'hFFFF) begin
            cur_col++;
         end
      end

      for (int i = 0; i < run_count && i < 2; i++) begin
         tok = run_tokens[1'(i)];
         tok.last = (i == run_count - 1);
         want_ring[wr_idx] = tok;
         wr_idx++;
         fill++;
      end
   endtask

   task automatic compare_token();
      nl_lex_pkg::result_type want;
      if (fill == 0) begin
         errs++;
         if (errs <= 10)
            $display("unexpected token: kind %0d value %0d line %0d col %0d len %0d last %0d",
                     rsp_token_kind, rsp_number_value, rsp_token_line, rsp_token_column,
                     rsp_token_length, rsp_last_of_run);
      end else begin
         want = want_ring[rd_idx];
         rd_idx++;
         fill--;
         if (want.kind !== rsp_token_kind || want.value !== rsp_number_value ||
             want.line !== rsp_token_line || want.column !== rsp_token_column ||
             want.length !== rsp_token_length || want.last !== rsp_last_of_run) begin
            errs++;
            if (errs <= 10) begin
               $display({"token mismatch: expected kind %0d value %0d line %0d col %0d",
                         " len %0d last %0d"},
                        want.kind, want.value, want.line, want.column, want.length, want.last);
               $display({"                got      kind %0d value %0d line %0d col %0d",
                         " len %0d last %0d"},
                        rsp_token_kind, rsp_number_value, rsp_token_line, rsp_token_column,
                        rsp_token_length, rsp_last_of_run);
            end
         end
      end
   endtask

   initial begin
      errs = 0;
      fail_count = 0;
      pending = 0;
      rd_idx = 4'd0;
      wr_idx = 4'd0;
      fill = 0;
      run_count = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         mode = LX_IDLE;
         acc = 64'd0;
         foreach (kw_buf[i]) kw_buf[i] = 8'h00;
         wlen = 16'd0;
         cur_line = 32'd1;
         cur_col = 16'd0;
         tok_line = 32'd1;
         tok_col = 16'd0;
         closer_paren = 1'b0;
         rd_idx = 4'd0;
         wr_idx = 4'd0;
         fill = 0;
         pending <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) compare_token();
         if (req_valid && !req_stall) predict_request(req_char_byte, req_end_of_input);
         pending <= fill;
         fail_count <= errs;
      end
   end

endmodule

// ===== tb/netlist_lexer_tb.sv =====
`timescale 1ns / 100ps
module netlist_lexer_tb;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_char_byte;
   logic        req_end_of_input;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [4:0]  rsp_token_kind;
   logic [62:0] rsp_number_value;
   logic [31:0] rsp_token_line;
   logic [15:0] rsp_token_column;
   logic [15:0] rsp_token_length;
   logic        rsp_last_of_run;
   int          fail_count;
   int          pending;
   logic        quiet;
   int          req_count;

   netlist_lexer dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_char_byte(req_char_byte),
      .req_end_of_input(req_end_of_input),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_token_kind(rsp_token_kind),
      .rsp_number_value(rsp_number_value),
      .rsp_token_line(rsp_token_line),
      .rsp_token_column(rsp_token_column),
      .rsp_token_length(rsp_token_length),
      .rsp_last_of_run(rsp_last_of_run)
   );

   netlist_lexer_checker token_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_char_byte(req_char_byte),
      .req_end_of_input(req_end_of_input),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_token_kind(rsp_token_kind),
      .rsp_number_value(rsp_number_value),
      .rsp_token_line(rsp_token_line),
      .rsp_token_column(rsp_token_column),
      .rsp_token_length(rsp_token_length),
      .rsp_last_of_run(rsp_last_of_run),
      .fail_count(fail_count),
      .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #8_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic send_req(input logic [7:0] c, input logic eoi);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 15);
      repeat (gap) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_char_byte <= c;
      req_end_of_input <= eoi;
      do @(posedge clock); while (req_stall);
      req_count++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_req(s[i], 1'b0);
   endtask

   function automatic logic [7:0] rand_alnum();
      int r;
      r = $urandom_range(0, 63);
      if (r < 26) return 8'("a" + r);
      if (r < 52) return 8'("A" + r - 26);
      if (r < 62) return 8'("0" + r - 52);
      if (r == 62) return nl_lex_pkg::CH_UNDER;
      return nl_lex_pkg::CH_DOLLAR;
   endfunction

   function automatic logic [7:0] rand_blank();
      case ($urandom_range(0, 3))
         0: return nl_lex_pkg::CH_SPACE;
         1: return nl_lex_pkg::CH_TAB;
         2: return nl_lex_pkg::CH_CR;
         default: return nl_lex_pkg::CH_LF;
      endcase
   endfunction

   function automatic logic [7:0] rand_punct();
      case ($urandom_range(0, 9))
         0: return nl_lex_pkg::CH_LPAREN;
         1: return nl_lex_pkg::CH_RPAREN;
         2: return nl_lex_pkg::CH_LBRACK;
         3: return nl_lex_pkg::CH_RBRACK;
         4: return nl_lex_pkg::CH_COMMA;
         5: return nl_lex_pkg::CH_DOT;
         6: return nl_lex_pkg::CH_SEMI;
         7: return nl_lex_pkg::CH_COLON;
         8: return nl_lex_pkg::CH_EQUAL;
         default: return nl_lex_pkg::CH_TICK;
      endcase
   endfunction

   initial begin : result_side
      int w;
      rsp_stall <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         w = quiet ? 0 : $urandom_range(0, 15);
         if (w > 0) begin
            rsp_stall <= 1'b1;
            repeat (w) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   initial begin : stimulus
      int          n;
      int          start_count;
      int          k;
      logic [7:0]  b;
      logic [7:0]  prev;
      logic [7:0]  closer_ch;
      quiet = 1'b0;
      req_count = 0;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_char_byte <= 8'h00;
      req_end_of_input <= 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Every punctuation kind, a pending paren closed by whitespace and both comment forms.
      send_text("(a)[0],.;:='\\e\t/**/(*)*)(\r\n");
      send_req(8'hFF, 1'b1);
      send_text("_Z$9(");
      send_req(8'h00, 1'b1);

      start_count = req_count;
      while (req_count - start_count < 1000) begin
         if ($urandom_range(0, 29) == 0) quiet = !quiet;
         k = $urandom_range(0, 99);
         if (k < 30) begin
            if ($urandom_range(0, 2) == 0) begin
               n = $urandom_range(0, nl_lex_pkg::KW_COUNT - 1);
               for (int j = 0; j < nl_lex_pkg::KW_LEN[n]; j++)
                  send_req(nl_lex_pkg::KW_TEXT[n][j], 1'b0);
               if ($urandom_range(0, 3) == 0) send_req(rand_alnum(), 1'b0);
            end else begin
               if ($urandom_range(0, 1)) send_req(8'("a" + $urandom_range(0, 25)), 1'b0);
               else send_req(nl_lex_pkg::CH_UNDER, 1'b0);
               repeat ($urandom_range(0, 11)) send_req(rand_alnum(), 1'b0);
            end
         end else if (k < 45) begin
            if ($urandom_range(0, 15) == 0) begin
               send_text("9223372036854775807");
            end else begin
               repeat ($urandom_range(1, 18)) send_req(8'("0" + $urandom_range(0, 9)), 1'b0);
            end
            send_req(rand_blank(), 1'b0);
         end else if (k < 55) begin
            send_req(nl_lex_pkg::CH_BSLASH, 1'b0);
            repeat ($urandom_range(0, 8)) begin
               do b = 8'($urandom_range(0, 255));
               while (b == nl_lex_pkg::CH_SPACE || b == nl_lex_pkg::CH_TAB ||
                      b == nl_lex_pkg::CH_CR || b == nl_lex_pkg::CH_LF);
               send_req(b, 1'b0);
            end
            send_req(rand_blank(), 1'b0);
         end else if (k < 75) begin
            send_req(rand_punct(), 1'b0);
         end else if (k < 85) begin
            if ($urandom_range(0, 1)) begin
               send_req(nl_lex_pkg::CH_SLASH, 1'b0);
               closer_ch = nl_lex_pkg::CH_SLASH;
            end else begin
               send_req(nl_lex_pkg::CH_LPAREN, 1'b0);
               closer_ch = nl_lex_pkg::CH_RPAREN;
            end
            send_req(nl_lex_pkg::CH_STAR, 1'b0);
            prev = 8'h00;
            repeat ($urandom_range(0, 10)) begin
               b = ($urandom_range(0, 3) == 0) ? nl_lex_pkg::CH_STAR
                                                : 8'($urandom_range(0, 255));
               if (prev == nl_lex_pkg::CH_STAR && b == closer_ch) b = "x";
               send_req(b, 1'b0);
               prev = b;
            end
            send_req(nl_lex_pkg::CH_STAR, 1'b0);
            send_req(closer_ch, 1'b0);
         end else if (k < 97) begin
            repeat ($urandom_range(1, 3)) send_req(rand_blank(), 1'b0);
         end else begin
            send_req(8'($urandom_range(0, 255)), 1'b1);
         end
      end
      quiet = 1'b0;

      // A halting case ends the run (an open word may absorb it), then more random requests.
      case ($urandom_range(0, 3))
         0: begin
            if ($urandom_range(0, 1)) begin
               b = 8'($urandom_range(128, 255));
            end else begin
               case ($urandom_range(0, 9))
                  0: b = 8'h00;
                  1: b = "!";
                  2: b = "#";
                  3: b = "@";
                  4: b = "~";
                  5: b = nl_lex_pkg::CH_STAR;
                  6: b = "{";
                  7: b = "%";
                  8: b = nl_lex_pkg::CH_DOLLAR;
                  default: b = 8'h7F;
               endcase
            end
            send_req(b, 1'b0);
         end
         1: begin
            send_req(nl_lex_pkg::CH_SLASH, 1'b0);
            case ($urandom_range(0, 2))
               0: send_req("a", 1'b0);
               1: send_req(nl_lex_pkg::CH_SLASH, 1'b0);
               default: send_req(8'($urandom_range(0, 255)), 1'b1);
            endcase
         end
         2: begin
            if ($urandom_range(0, 1)) send_text("92233720368547758080");
            else send_text("9223372036854775808");
            if ($urandom_range(0, 1)) send_req(nl_lex_pkg::CH_SPACE, 1'b0);
            else send_req(8'($urandom_range(0, 255)), 1'b1);
         end
         default: begin
            send_req($urandom_range(0, 1) ? nl_lex_pkg::CH_SLASH : nl_lex_pkg::CH_LPAREN, 1'b0);
            send_req(nl_lex_pkg::CH_STAR, 1'b0);
            repeat ($urandom_range(0, 3))
               send_req($urandom_range(0, 1) ? nl_lex_pkg::CH_STAR : "q", 1'b0);
            send_req(8'($urandom_range(0, 255)), 1'b1);
         end
      endcase
      repeat (8) send_req(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

      req_valid <= 1'b0;
      @(posedge clock);
      for (k = 0; k < 4000 && pending != 0; k++) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
